### sv/thermistor_temperature_from_adc_assert.svh
// Assertion macros for the thermistor temperature block checkers.
`ifndef THERMISTOR_TEMPERATURE_FROM_ADC_ASSERT_SVH
`define THERMISTOR_TEMPERATURE_FROM_ADC_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TTADC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttadc assertion failed");

// Next-cycle implication, disabled in reset.
`define TTADC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttadc assertion failed");

`endif

### sv/ttadc_pkg.sv
// Shared types and constants of the thermistor temperature block.
`default_nettype none
package ttadc_pkg;

   localparam logic [31:0]  RSERIES    = 32'd64900;
   localparam logic [63:0]  LN2_Q63    = 64'h58B9_0BFB_E8E7_BCD5;
   localparam logic [24:0]  TEMP_MAX   = 25'h1FF_FFFF;
   localparam logic [6:0]   DIV_TOP    = 7'd104;
   localparam logic [127:0] SAT_LIMIT  = 128'h0000_0000_0000_8000_0000_0000_0000_0000;

   localparam logic [1:0]   REG_COEFF_A = 2'd0;
   localparam logic [1:0]   REG_COEFF_B = 2'd1;
   localparam logic [1:0]   REG_COEFF_C = 2'd2;

   typedef struct packed {
      logic [24:0] temperature_k;
      logic [17:0] drive_voltage;
      logic        healthy;
      logic        domain_error;
   } ttadc_result_type;

endpackage
`default_nettype wire

### sv/ttadc_mul32.sv
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none
module ttadc_mul32 (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = mul_a * mul_b;
   assign mul_p   = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

### sv/ttadc_core.sv
// Sequencer and datapath: log2 and ln polynomial over one multiplier, reciprocal by a bit-serial divider.
`default_nettype none
module ttadc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [15:0]                 sample,
   input  logic [63:0]                 coeff_a,
   input  logic [63:0]                 coeff_b,
   input  logic [63:0]                 coeff_c,
   input  logic                        out_free,
   output logic                        busy,
   output logic                        done,
   output ttadc_pkg::ttadc_result_type result
);
   import ttadc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_NUM, ST_NORM, ST_SQ_ISSUE, ST_SQ_TAKE,
      ST_MUL, ST_MUL_FIN, ST_CHECKD, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MOP_LN, MOP_L2, MOP_L3, MOP_B, MOP_C
   } mop_type;

   state_type      state_ff, state_in;
   mop_type        mop_ff, mop_in;
   logic           toggle_ff, toggle_in;
   logic [15:0]    cur_ff, cur_in;
   logic [15:0]    volt_ff, volt_in;
   logic [17:0]    held_ff, held_in;
   logic           healthy_ff, healthy_in;
   logic           derr_ff, derr_in;
   logic [24:0]    temp_ff, temp_in;
   logic [31:0]    x_ff, x_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [4:0]     e_ff, e_in;
   logic [31:0]    frac_ff, frac_in;
   logic           lsel_ff, lsel_in;
   logic [36:0]    lognum_ff, lognum_in;
   logic [63:0]    d_ff, d_in;
   logic [2:0]     step_ff, step_in;
   logic [127:0]   acc_ff, acc_in;
   logic [63:0]    l_ff, l_in;
   logic [63:0]    l2_ff, l2_in;
   logic [63:0]    l3_ff, l3_in;
   logic [127:0]   dacc_ff, dacc_in;
   logic [127:0]   rem_ff, rem_in;
   logic [24:0]    q_ff, q_in;

   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_p;
   logic [63:0]    opa, opb, ua, ub;
   logic           neg;
   logic [31:0]    pp_a, pp_b;
   logic [127:0]   pp_shifted;
   logic [127:0]   sp;

   ttadc_mul32 u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // operand select for the signed 64x64 product
   always_comb begin
      unique case (mop_ff)
         MOP_LN: begin opa = d_ff;    opb = LN2_Q63; end
         MOP_L2: begin opa = l_ff;    opb = l_ff;    end
         MOP_L3: begin opa = l2_ff;   opb = l_ff;    end
         MOP_B:  begin opa = coeff_b; opb = l_ff;    end
         MOP_C:  begin opa = coeff_c; opb = l3_ff;   end
         default: begin opa = '0;     opb = '0;      end
      endcase
   end

   assign ua  = opa[63] ? (64'd0 - opa) : opa;
   assign ub  = opb[63] ? (64'd0 - opb) : opb;
   assign neg = opa[63] ^ opb[63];
   assign sp  = neg ? (128'd0 - acc_ff) : acc_ff;

   // partial product k: lo*lo, lo*hi, hi*lo, hi*hi
   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin pp_a = ua[31:0];  pp_b = ub[31:0];  end
         2'd1: begin pp_a = ua[31:0];  pp_b = ub[63:32]; end
         2'd2: begin pp_a = ua[63:32]; pp_b = ub[31:0];  end
         default: begin pp_a = ua[63:32]; pp_b = ub[63:32]; end
      endcase
   end

   // product arriving now was issued one step earlier
   always_comb begin
      unique case (step_ff)
         3'd1:         pp_shifted = {64'd0, mul_p};
         3'd2, 3'd3:   pp_shifted = {32'd0, mul_p, 32'd0};
         3'd4:         pp_shifted = {mul_p, 64'd0};
         default:      pp_shifted = '0;
      endcase
   end

   always_comb begin
      logic        hlth;
      logic [31:0] frac_nxt;
      logic [36:0] log_val;
      logic [127:0] r2;
      logic        ge;
      logic [24:0] q_nxt;

      hlth     = 1'b0;
      frac_nxt = '0;
      log_val  = '0;
      r2       = '0;
      ge       = 1'b0;
      q_nxt    = '0;

      state_in   = state_ff;
      mop_in     = mop_ff;
      toggle_in  = toggle_ff;
      cur_in     = cur_ff;
      volt_in    = volt_ff;
      held_in    = held_ff;
      healthy_in = healthy_ff;
      derr_in    = derr_ff;
      temp_in    = temp_ff;
      x_in       = x_ff;
      cnt_in     = cnt_ff;
      e_in       = e_ff;
      frac_in    = frac_ff;
      lsel_in    = lsel_ff;
      lognum_in  = lognum_ff;
      d_in       = d_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      l_in       = l_ff;
      l2_in      = l2_ff;
      l3_in      = l3_ff;
      dacc_in    = dacc_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      mul_a      = '0;
      mul_b      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!toggle_ff) cur_in = sample;
               else            volt_in = sample;
               toggle_in = ~toggle_ff;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            hlth       = (cur_ff != 16'd0) && (volt_ff != 16'd0);
            healthy_in = hlth;
            temp_in    = '0;
            derr_in    = 1'b0;
            if (!hlth) begin
               state_in = ST_DONE;
            end else begin
               held_in = {2'b00, cur_ff} + {1'b0, cur_ff, 1'b0};
               if (volt_ff <= cur_ff) begin
                  derr_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  mul_a    = RSERIES;
                  mul_b    = {16'd0, volt_ff - cur_ff};
                  state_in = ST_NUM;
               end
            end
         end
         ST_NUM: begin
            x_in     = mul_p[31:0];
            cnt_in   = '0;
            lsel_in  = 1'b0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // one bit of leading-one search per cycle
            if (x_ff[31]) begin
               e_in     = 5'd31 - cnt_ff[4:0];
               cnt_in   = '0;
               frac_in  = '0;
               state_in = ST_SQ_ISSUE;
            end else begin
               x_in   = {x_ff[30:0], 1'b0};
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_SQ_ISSUE: begin
            mul_a    = x_ff;
            mul_b    = x_ff;
            state_in = ST_SQ_TAKE;
         end
         ST_SQ_TAKE: begin
            if (mul_p[63]) begin
               x_in     = mul_p[63:32];
               frac_nxt = {frac_ff[30:0], 1'b1};
            end else begin
               x_in     = mul_p[62:31];
               frac_nxt = {frac_ff[30:0], 1'b0};
            end
            frac_in = frac_nxt;
            log_val = {e_ff, frac_nxt};
            if (cnt_ff[4:0] == 5'd31) begin
               cnt_in = '0;
               if (!lsel_ff) begin
                  lognum_in = log_val;
                  x_in      = {16'd0, cur_ff};
                  lsel_in   = 1'b1;
                  state_in  = ST_NORM;
               end else begin
                  d_in     = {27'd0, lognum_ff} - {27'd0, log_val};
                  dacc_in  = {{32{coeff_a[63]}}, coeff_a, 32'd0};
                  mop_in   = MOP_LN;
                  step_in  = '0;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            end else begin
               cnt_in   = cnt_ff + 7'd1;
               state_in = ST_SQ_ISSUE;
            end
         end
         ST_MUL: begin
            mul_a  = pp_a;
            mul_b  = pp_b;
            acc_in = acc_ff + pp_shifted;
            if (step_ff == 3'd4) state_in = ST_MUL_FIN;
            else                 step_in  = step_ff + 3'd1;
         end
         ST_MUL_FIN: begin
            step_in = '0;
            acc_in  = '0;
            unique case (mop_ff)
               MOP_LN: begin l_in  = sp[126:63]; mop_in = MOP_L2; state_in = ST_MUL; end
               MOP_L2: begin l2_in = sp[95:32];  mop_in = MOP_L3; state_in = ST_MUL; end
               MOP_L3: begin l3_in = sp[95:32];  mop_in = MOP_B;  state_in = ST_MUL; end
               MOP_B: begin
                  dacc_in  = neg ? (dacc_ff - acc_ff) : (dacc_ff + acc_ff);
                  mop_in   = MOP_C;
                  state_in = ST_MUL;
               end
               default: begin
                  dacc_in  = neg ? (dacc_ff - acc_ff) : (dacc_ff + acc_ff);
                  state_in = ST_CHECKD;
               end
            endcase
         end
         ST_CHECKD: begin
            priority if (dacc_ff[127] || (dacc_ff == 128'd0)) begin
               derr_in  = 1'b1;
               state_in = ST_DONE;
            end else if (dacc_ff <= SAT_LIMIT) begin
               temp_in  = TEMP_MAX;
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               q_in     = '0;
               cnt_in   = DIV_TOP;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division of 2^104 by the denominator, one bit per cycle
            r2    = {rem_ff[126:0], cnt_ff == DIV_TOP};
            ge    = r2 >= dacc_ff;
            rem_in = ge ? (r2 - dacc_ff) : r2;
            q_nxt = {q_ff[23:0], ge};
            q_in  = q_nxt;
            if (cnt_ff == 7'd0) begin
               temp_in  = q_nxt;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         toggle_ff <= 1'b0;
         cur_ff    <= '0;
         volt_ff   <= '0;
         held_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         toggle_ff <= toggle_in;
         cur_ff    <= cur_in;
         volt_ff   <= volt_in;
         held_ff   <= held_in;
      end
      mop_ff     <= mop_in;
      healthy_ff <= healthy_in;
      derr_ff    <= derr_in;
      temp_ff    <= temp_in;
      x_ff       <= x_in;
      cnt_ff     <= cnt_in;
      e_ff       <= e_in;
      frac_ff    <= frac_in;
      lsel_ff    <= lsel_in;
      lognum_ff  <= lognum_in;
      d_ff       <= d_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      l_ff       <= l_in;
      l2_ff      <= l2_in;
      l3_ff      <= l3_in;
      dacc_ff    <= dacc_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

   assign result.temperature_k = temp_ff;
   assign result.drive_voltage = held_ff;
   assign result.healthy       = healthy_ff;
   assign result.domain_error  = derr_ff;
endmodule
`default_nettype wire

### sv/thermistor_temperature_from_adc.sv
// Top level: thermistor temperature from alternating ADC readings.
// Each req transfer carries one raw ADC word; words alternate current channel,
// then voltage channel, starting with current after reset. Each transfer yields
// one rsp transfer with the Steinhart-Hart temperature (2^-16 K, saturated),
// the drive voltage (current reading * 3, 1/16 mV), a health flag (both kept
// readings nonzero) and a domain-error flag (resistance or denominator not
// positive). An unhealthy reading, or one whose voltage word is not above the
// current word, finishes right after the check; every other reading runs the
// full conversion from the req transfer to a valid rsp over the single shared
// 32x32 multiplier (two leading-one searches, two 32-step log2 squaring
// loops, five 64x64 products) and then the bit-serial divider.
// A non-positive or saturating denominator ends just before the divider.
// req_stall is high while an item is in work; a finished result waits in the
// rsp output register, so a new req transfer may start while it is unread.
// Coefficients are 64-bit two's complement (scale 2^-56) at byte addresses
// 0, 8 and 16 of the APB-style port; write them only while the block is idle.
`default_nettype none
module thermistor_temperature_from_adc (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_adc_sample,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_temperature_k,
   output logic [17:0] rsp_drive_voltage,
   output logic        rsp_healthy,
   output logic        rsp_domain_error,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import ttadc_pkg::*;

   logic [63:0]      coeff_a_ff, coeff_a_in;
   logic [63:0]      coeff_b_ff, coeff_b_in;
   logic [63:0]      coeff_c_ff, coeff_c_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ttadc_result_type rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic             start;
   logic             out_free;
   logic             core_busy;
   logic             core_done;
   ttadc_result_type core_result;

   // register write on the access phase
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      coeff_a_in = coeff_a_ff;
      coeff_b_in = coeff_b_ff;
      coeff_c_in = coeff_c_ff;
      if (wr_en) begin
         unique case (paddr[4:3])
            REG_COEFF_A: coeff_a_in = pwdata;
            REG_COEFF_B: coeff_b_in = pwdata;
            REG_COEFF_C: coeff_c_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_COEFF_A: prdata = coeff_a_ff;
         REG_COEFF_B: prdata = coeff_b_ff;
         REG_COEFF_C: prdata = coeff_c_ff;
         default:     prdata = '0;
      endcase
   end

   // one item in work at a time
   assign req_stall = core_busy;
   assign start     = req_valid && !req_stall;

   // output register frees when empty or its transfer completes
   assign out_free = !rsp_valid_ff || !rsp_stall;

   ttadc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .sample  (req_adc_sample),
      .coeff_a (coeff_a_ff),
      .coeff_b (coeff_b_ff),
      .coeff_c (coeff_c_ff),
      .out_free(out_free),
      .busy    (core_busy),
      .done    (core_done),
      .result  (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff   <= '0;
         coeff_b_ff   <= '0;
         coeff_c_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coeff_a_ff   <= coeff_a_in;
         coeff_b_ff   <= coeff_b_in;
         coeff_c_ff   <= coeff_c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temperature_k = rsp_data_ff.temperature_k;
   assign rsp_drive_voltage = rsp_data_ff.drive_voltage;
   assign rsp_healthy       = rsp_data_ff.healthy;
   assign rsp_domain_error  = rsp_data_ff.domain_error;
endmodule
`default_nettype wire

### sv/ttadc_checker.sv
// Port-level checker for the thermistor temperature block, with its bind.
`default_nettype none
`include "thermistor_temperature_from_adc_assert.svh"
module ttadc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [24:0] rsp_temperature_k,
   input wire logic [17:0] rsp_drive_voltage,
   input wire logic        rsp_healthy,
   input wire logic        rsp_domain_error
);
   // a stalled result keeps its temperature
   `TTADC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_temperature_k))
   // unhealthy results carry a zero temperature and no domain error
   `TTADC_ASSERT_IMPLY(a_unhealthy, clock, reset, rsp_valid && !rsp_healthy, (rsp_temperature_k == 25'd0) && !rsp_domain_error)
   // a domain error forces a zero temperature
   `TTADC_ASSERT_IMPLY(a_domain_zero, clock, reset, rsp_valid && rsp_domain_error, rsp_temperature_k == 25'd0)
   // drive voltage is at most three full-scale readings
   `TTADC_ASSERT_IMPLY(a_drive_range, clock, reset, rsp_valid, rsp_drive_voltage <= 18'd196605)
endmodule

bind thermistor_temperature_from_adc ttadc_checker u_ttadc_checker (.*);
`default_nettype wire

### tb/sv/tb_thermistor_temperature_from_adc.sv
// Self-checking testbench for the thermistor temperature block.
`timescale 1ns / 1ps
`default_nettype none
module tb_thermistor_temperature_from_adc;
   import ttadc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000; // cycles without any transfer
   localparam int DRAIN_CYCLES   = 400;   // longer than the longest full conversion
   localparam int HOLD_CYCLES    = 1500;  // long receiver hold-off
   localparam int RANDOM_PER_SET = 270;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_adc_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [24:0] rsp_temperature_k;
   logic [17:0] rsp_drive_voltage;
   logic        rsp_healthy;
   logic        rsp_domain_error;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   thermistor_temperature_from_adc dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // words waiting to be offered, and results the block still owes us
   logic [15:0]      sample_queue[$];
   ttadc_result_type owed_results[$];

   // our own copy of the block state and coefficients
   logic [63:0] coef_a = '0, coef_b = '0, coef_c = '0;
   logic        next_is_volt = 1'b0;
   logic [15:0] cur_word = '0, volt_word = '0;
   logic [17:0] held_drive = '0;

   int  error_count = 0;
   int  sent_count = 0, got_count = 0;
   int  healthy_count = 0, derr_count = 0, sat_count = 0;
   int  idle_cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  no_idle = 1'b0;

   function automatic logic signed [127:0] sx(logic [63:0] x);
      return {{64{x[63]}}, x};
   endfunction

   // log2 in Q32: top-bit index, then 32 fraction bits by repeated squaring
   function automatic logic [63:0] log2_fix(logic [63:0] x);
      int          e;
      logic [63:0] m, frac;
      e = 0;
      frac = '0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {e[31:0], frac[31:0]};
   endfunction

   // expected result of one accepted ADC word; updates the state copy
   function automatic ttadc_result_type convert_sample(logic [15:0] s);
      ttadc_result_type r;
      logic [63:0]         num, d, ln_r, ln2_r, ln3_r;
      logic signed [127:0] p, den;
      logic [127:0]        q;
      if (!next_is_volt) cur_word = s;
      else volt_word = s;
      next_is_volt = !next_is_volt;
      r = '0;
      r.healthy = (cur_word != 0) && (volt_word != 0);
      if (r.healthy) begin
         held_drive = 18'(cur_word) * 18'd3;
         if (volt_word <= cur_word) begin
            r.domain_error = 1'b1;
         end else begin
            num = 64'(RSERIES) * 64'(volt_word - cur_word);
            d = log2_fix(num) - log2_fix(64'(cur_word));
            p = sx(d) * $signed({64'b0, LN2_Q63});
            ln_r = p[126:63];
            p = sx(ln_r) * sx(ln_r);
            ln2_r = p[95:32];
            p = sx(ln2_r) * sx(ln_r);
            ln3_r = p[95:32];
            den = (sx(coef_a) <<< 32) + sx(coef_b) * sx(ln_r) + sx(coef_c) * sx(ln3_r);
            if (den <= 0) begin
               r.domain_error = 1'b1;
            end else if (den <= $signed(SAT_LIMIT)) begin
               r.temperature_k = TEMP_MAX;
            end else begin
               q = (128'd1 << 104) / unsigned'(den);
               r.temperature_k = (q > 128'(TEMP_MAX)) ? TEMP_MAX : q[24:0];
            end
         end
      end
      r.drive_voltage = held_drive;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, got_count);
   endtask

   // driver: holds a stalled word, else offers the next one or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_adc_sample <= '0;
      end else if (!req_valid || !req_stall) begin
         if (sample_queue.size() > 0 && (no_idle || $urandom_range(99) >= 21)) begin
            req_valid <= 1'b1;
            req_adc_sample <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random, plus one long hold-off mid-run to back up the input
   always @(posedge clock) begin
      if (!hold_done && sent_count == 700) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= reset || hold_left > 1 || (!no_idle && $urandom_range(99) < 21);
   end

   // monitor: results are checked before the same-edge input transfer is predicted
   always @(posedge clock) begin
      ttadc_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_temperature_k !== want.temperature_k)
                  report_mismatch("temperature_k", 32'(rsp_temperature_k),
                                  32'(want.temperature_k));
               if (rsp_drive_voltage !== want.drive_voltage)
                  report_mismatch("drive_voltage", 32'(rsp_drive_voltage),
                                  32'(want.drive_voltage));
               if (rsp_healthy !== want.healthy)
                  report_mismatch("healthy", 32'(rsp_healthy), 32'(want.healthy));
               if (rsp_domain_error !== want.domain_error)
                  report_mismatch("domain_error", 32'(rsp_domain_error),
                                  32'(want.domain_error));
               healthy_count += want.healthy;
               derr_count += want.domain_error;
               sat_count += (want.temperature_k == TEMP_MAX);
            end
            got_count++;
         end
         if (req_valid && !req_stall) begin
            owed_results.push_back(convert_sample(req_adc_sample));
            sent_count++;
         end
      end
   end

   // watchdog on transfers of either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // APB write: setup then access; the register loads at the access edge
   task automatic write_coeff(logic [1:0] idx, logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_COEFF_A: coef_a = value;
         REG_COEFF_B: coef_b = value;
         default:     coef_c = value;
      endcase
   endtask

   // sender pause: nothing left to offer and every result back, plus slack
   task automatic wait_drained();
      wait (sample_queue.size() == 0 && owed_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_coeffs(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      write_coeff(REG_COEFF_A, a);
      write_coeff(REG_COEFF_B, b);
      write_coeff(REG_COEFF_C, c);
   endtask

   // one current/voltage pair; mostly plausible readings, plus edge shapes
   task automatic push_pair();
      logic [15:0] c, v;
      int          kind;
      kind = $urandom_range(99);
      if (kind < 60) begin
         c = 16'($urandom_range(60000, 1));
         v = 16'($urandom_range(65535, c + 1));
      end else if (kind < 68) begin
         c = 16'($urandom_range(65534, 1));
         v = c + 16'($urandom_range(3, 1) > 65535 - c ? 1 : $urandom_range(3, 1));
      end else if (kind < 76) begin
         c = 16'($urandom);
         v = 16'($urandom_range(c, 0));
      end else if (kind < 84) begin
         c = ($urandom_range(1) == 1) ? 16'd0 : 16'($urandom);
         v = ($urandom_range(1) == 1) ? 16'd0 : 16'($urandom);
      end else begin
         c = 16'($urandom);
         v = 16'($urandom);
      end
      sample_queue.push_back(c);
      sample_queue.push_back(v);
      // an odd word now and then shifts which channel the next word lands on
      if ($urandom_range(99) < 3) sample_queue.push_back(16'($urandom));
   endtask

   initial begin
      logic [63:0] set_a[6], set_b[6], set_c[6];
      logic [15:0] directed[$];
      // realistic NTC constants at 2^-56: about 1e-3, 2.5e-4, 1e-7
      set_a[0] = 64'd72057594037928;
      set_b[0] = 64'd18014398509482;
      set_c[0] = 64'd7205759404;
      set_a[1] = 64'h7FFF_FFFF_FFFF_FFFF;
      set_b[1] = 64'h7FFF_FFFF_FFFF_FFFF;
      set_c[1] = 64'h7FFF_FFFF_FFFF_FFFF;
      set_a[2] = 64'h8000_0000_0000_0000;
      set_b[2] = 64'h8000_0000_0000_0000;
      set_c[2] = 64'h8000_0000_0000_0000;
      set_a[3] = 64'd1;                   // tiny denominator: saturates
      set_b[3] = 64'd0;
      set_c[3] = 64'd0;
      set_a[4] = 64'($urandom) << 32 | 64'($urandom);
      set_b[4] = (64'($urandom) << 32 | 64'($urandom)) >>> 8;
      set_c[4] = (64'($urandom) << 32 | 64'($urandom)) >>> 16;
      set_a[5] = 64'd0;                   // zero denominator: domain error
      set_b[5] = 64'd0;
      set_c[5] = 64'd0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      load_coeffs(set_a[0], set_b[0], set_c[0]);
      // directed pairs: both readings missing, full scale, equal, reversed,
      // minimum difference, one side missing (drive voltage must hold)
      directed = '{16'd0, 16'd0, 16'd1, 16'd65535, 16'd65535, 16'd65535,
                   16'd30000, 16'd20000, 16'd1, 16'd2, 16'd65534, 16'd65535,
                   16'd20000, 16'd40000, 16'd0, 16'd40000, 16'd1000, 16'd0,
                   16'd32768, 16'd32769, 16'd12345, 16'd54321, 16'd21845, 16'd43690};
      foreach (directed[i]) sample_queue.push_back(directed[i]);
      wait_drained();

      for (int s = 0; s < 6; s++) begin
         load_coeffs(set_a[s], set_b[s], set_c[s]);
         no_idle = (s == 2);              // one stretch with no bubbles on either side
         for (int k = 0; k < RANDOM_PER_SET / 2; k++) push_pair();
         wait_drained();
      end
      no_idle = 1'b0;

      if (owed_results.size() != 0) report_mismatch("results never delivered",
                                                    32'(owed_results.size()), 32'd0);
      $display("covered %0d ADC words over 6 coefficient sets (incl. extremes and zero)",
               sent_count);
      $display("results: %0d healthy, %0d domain errors, %0d saturated",
               healthy_count, derr_count, sat_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

### thermistor_temperature_from_adc.f
+incdir+sv
sv/ttadc_pkg.sv
sv/ttadc_mul32.sv
sv/ttadc_core.sv
sv/thermistor_temperature_from_adc.sv
sv/ttadc_checker.sv
tb/sv/tb_thermistor_temperature_from_adc.sv
